/* hdl/assert_macros.svh */
// assertion macros used by the scheduler controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock, masked during reset
`define ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// next-cycle implication, masked during reset
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

/* hdl/mpts_pkg.sv */
// shared types and constants of the task scheduler
package mpts_pkg;
    localparam int NUM_SLOTS = 8;
    localparam int SW = $clog2(NUM_SLOTS);
    localparam int CW = $clog2(NUM_SLOTS + 1);

    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_STATE = 2'd1;
    localparam logic [1:0] ACT_SLICE = 2'd2;

    localparam logic [1:0] ST_READY    = 2'd1;
    localparam logic [1:0] ST_SLEEPING = 2'd2;

    localparam logic [1:0] POL_RR   = 2'd0;
    localparam logic [1:0] POL_PRIO = 2'd1;
    localparam logic [1:0] POL_FCFS = 2'd2;
    localparam logic [1:0] POL_SJF  = 2'd3;

    localparam logic [1:0] REG_POLICY = 2'd0;
    localparam logic [1:0] REG_PAUSE  = 2'd1;
    localparam logic [1:0] REG_EXEMPT = 2'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [2:0]  slot_index;
        logic [7:0]  task_ident;
        logic [1:0]  new_state;
        logic [7:0]  task_priority;
        logic [15:0] burst_guess;
        logic [31:0] wake_time;
        logic        shell_flag;
        logic [31:0] now_time;
    } t_item;

    // controller to datapath
    typedef struct packed {
        logic          capture;   // latch the input item
        logic          write;     // apply load or set-state
        logic          scan_clr;  // start a scan
        logic          scan_step; // examine slot scan_idx
        logic [SW-1:0] scan_idx;
        logic          commit;    // update counters and result
    } t_cmd;
endpackage

/* hdl/mpts_datapath.sv */
// slot table, per-slot scan step and result register
module mpts_datapath import mpts_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  t_item       i_item,
    input  logic [1:0]  i_policy,
    input  logic        i_pause,
    input  logic [7:0]  i_exempt,
    output logic [1:0]  o_action,
    output logic [7:0]  o_res_pack_dummy,
    output logic        o_ran,
    output logic [2:0]  o_slot,
    output logic [7:0]  o_id,
    output logic [31:0] o_ticks
);
    logic [1:0]  r_state [NUM_SLOTS];
    logic [7:0]  r_sid   [NUM_SLOTS];
    logic [7:0]  r_prio  [NUM_SLOTS];
    logic [31:0] r_runs  [NUM_SLOTS];
    logic [15:0] r_burst [NUM_SLOTS];
    logic [31:0] r_wake  [NUM_SLOTS];
    logic        r_shell [NUM_SLOTS];
    logic [SW-1:0] r_rr;
    logic [31:0] r_ticks;
    t_item       r_item;
    // scan results
    logic [SW-1:0] r_pick, r_sh, r_rrp;
    logic        r_pick_v, r_sh_v, r_rrp_v;
    logic [7:0]  r_pid, r_pprio;
    logic [31:0] r_pruns;
    logic [15:0] r_pburst;
    logic        r_ran;
    logic [2:0]  r_oslot;
    logic [7:0]  r_oid;

    // view of slot under scan, with wake-up applied
    logic [SW-1:0] idx;
    logic [1:0]  cur_st;
    logic        runnable, beats, rr_hit;
    logic [SW-1:0] fin;
    logic        fin_v;
    assign idx = i_cmd.scan_idx;
    always_comb begin
        cur_st = r_state[idx];
        if (cur_st == ST_SLEEPING && r_item.now_time >= r_wake[idx]) cur_st = ST_READY;
        runnable = cur_st == ST_READY && (!i_pause || r_sid[idx] == i_exempt);
        case (i_policy)
            POL_PRIO: beats = r_prio[idx] > r_pprio ||
                (r_prio[idx] == r_pprio && r_runs[idx] < r_pruns);
            POL_FCFS: beats = r_sid[idx] < r_pid;
            POL_SJF:  beats = r_burst[idx] < r_pburst ||
                (r_burst[idx] == r_pburst && r_sid[idx] < r_pid);
            default:  beats = 1'b0;
        endcase
        // round robin: first runnable at or after r_rr wins, else first overall
        rr_hit = runnable && (!r_rrp_v || (idx >= r_rr && r_rrp < r_rr));
        if (i_policy == POL_RR) begin
            fin = r_rrp; fin_v = r_rrp_v;
        end else if (r_sh_v && (!r_pick_v || r_ticks[1:0] == 2'd0)) begin
            fin = r_sh; fin_v = 1'b1;
        end else begin
            fin = r_pick; fin_v = r_pick_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_SLOTS; k++) begin
                r_state[k] <= '0; r_sid[k] <= '0; r_prio[k] <= '0; r_runs[k] <= '0;
                r_burst[k] <= '0; r_wake[k] <= '0; r_shell[k] <= 1'b0;
            end
            r_rr <= '0; r_ticks <= '0; r_ran <= 1'b0; r_oslot <= '0; r_oid <= '0;
            r_pick_v <= 1'b0; r_sh_v <= 1'b0; r_rrp_v <= 1'b0;
        end else begin
            if (i_cmd.capture) r_item <= i_item;
            // slot writes
            if (i_cmd.write && 32'(r_item.slot_index) < NUM_SLOTS) begin
                if (r_item.action == ACT_LOAD) begin
                    r_sid[SW'(r_item.slot_index)]   <= r_item.task_ident;
                    r_prio[SW'(r_item.slot_index)]  <= r_item.task_priority;
                    r_burst[SW'(r_item.slot_index)] <= r_item.burst_guess;
                    r_shell[SW'(r_item.slot_index)] <= r_item.shell_flag;
                    r_runs[SW'(r_item.slot_index)]  <= '0;
                end
                if (r_item.action == ACT_LOAD || r_item.action == ACT_STATE) begin
                    r_state[SW'(r_item.slot_index)] <= r_item.new_state;
                    r_wake[SW'(r_item.slot_index)]  <= r_item.wake_time;
                end
            end
            if (i_cmd.scan_clr) begin
                r_pick_v <= 1'b0; r_sh_v <= 1'b0; r_rrp_v <= 1'b0;
            end
            // one slot per cycle
            if (i_cmd.scan_step) begin
                r_state[idx] <= cur_st;
                if (runnable && r_shell[idx]) begin
                    r_sh <= idx; r_sh_v <= 1'b1;
                end else if (runnable && (!r_pick_v || beats)) begin
                    r_pick <= idx; r_pick_v <= 1'b1; r_pid <= r_sid[idx];
                    r_pprio <= r_prio[idx]; r_pruns <= r_runs[idx];
                    r_pburst <= r_burst[idx];
                end
                if (rr_hit) begin
                    r_rrp <= idx; r_rrp_v <= 1'b1;
                end
            end
            // result
            if (i_cmd.commit) begin
                if (r_item.action == ACT_SLICE) r_ticks <= r_ticks + 32'd1;
                if (r_item.action == ACT_SLICE && fin_v) begin
                    r_rr <= (32'(fin) == NUM_SLOTS - 1) ? '0 : fin + SW'(1);
                    r_runs[fin] <= r_runs[fin] + 32'd1;
                    r_ran <= 1'b1;
                    r_oslot <= 3'(fin);
                    r_oid <= r_sid[fin];
                end else begin
                    r_ran <= 1'b0; r_oslot <= '0; r_oid <= '0;
                end
            end
        end
    end
    assign o_action = r_item.action;
    assign o_res_pack_dummy = r_oid;
    assign o_ran = r_ran;
    assign o_slot = r_oslot;
    assign o_id = r_oid;
    assign o_ticks = r_ticks;
endmodule

/* hdl/mpts_ctrl.sv */
// sequencer: capture, write or slot scan, commit, present result
module mpts_ctrl import mpts_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  logic [1:0] i_action,
    output t_cmd       o_cmd
);
    `include "assert_macros.svh"
    typedef enum logic [2:0] {S_IDLE, S_DECODE, S_SCAN, S_COMMIT, S_OUT} t_state;
    t_state r_st, n_st;
    logic [SW-1:0] r_idx, n_idx;
    logic r_ov, n_ov;

    always_comb begin
        n_st = r_st; n_idx = r_idx; n_ov = r_ov;
        o_cmd = '0;
        o_cmd.scan_idx = r_idx;
        if (r_ov && i_out_ready) n_ov = 1'b0;
        unique case (r_st)
            S_IDLE: if (i_in_valid && !r_ov) begin
                o_cmd.capture = 1'b1; n_st = S_DECODE;
            end
            S_DECODE: begin
                o_cmd.write = 1'b1;
                o_cmd.scan_clr = 1'b1;
                n_idx = '0;
                n_st = (i_action == ACT_SLICE) ? S_SCAN : S_COMMIT;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (32'(r_idx) == NUM_SLOTS - 1) n_st = S_COMMIT;
                else n_idx = r_idx + SW'(1);
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1; n_ov = 1'b1; n_st = S_IDLE;
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_idx <= '0; r_ov <= 1'b0;
        end else begin
            r_st <= n_st; r_idx <= n_idx; r_ov <= n_ov;
        end
    end
    assign o_in_ready = r_st == S_IDLE && !r_ov;
    assign o_out_valid = r_ov;

    `ASSERT_NEXT(a_commit_valid, i_clk, i_rst_n, o_cmd.commit, r_ov)
    `ASSERT_IMPL(a_no_accept_busy, i_clk, i_rst_n, r_st != S_IDLE, !o_in_ready)
    `ASSERT_NEXT(a_capture_decode, i_clk, i_rst_n, o_cmd.capture, r_st == S_DECODE)
endmodule

/* hdl/multi_policy_task_scheduler.sv */
// top level of the multi-policy task scheduler
// channel  | dir | fields (low bit up)
// s_axis   | in  | tdata: action,slot_index,task_ident,new_state,priority,burst,wake,shell,now
// m_axis   | out | tdata: task_ran,chosen_slot,chosen_id,tick_total
// cfg      | in  | wr_en, index, data[7:0]
// a slice scans the slot table, one slot per cycle; other actions skip the scan
// and go straight to the commit; the result is held until the receiver takes it
// reset is synchronous, clears the slot table, counters and policy registers
// a new transaction is taken only after the previous result has been taken
module multi_policy_task_scheduler import mpts_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [103:0] s_axis_tdata, // action,slot,ident,state,prio,burst,wake,shell,now
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [47:0]  m_axis_tdata, // task_ran,chosen_slot,chosen_id,tick_total
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_index,
    input  logic [7:0]   i_cfg_data
);
    t_item it;
    t_cmd cmd;
    logic [1:0] act, r_pol;
    logic r_pause;
    logic [7:0] r_ex, unused_id;
    logic ran;
    logic [2:0] cs;
    logic [7:0] cid;
    logic [31:0] tk;

    assign it.action        = s_axis_tdata[1:0];
    assign it.slot_index    = s_axis_tdata[4:2];
    assign it.task_ident    = s_axis_tdata[12:5];
    assign it.new_state     = s_axis_tdata[14:13];
    assign it.task_priority = s_axis_tdata[22:15];
    assign it.burst_guess   = s_axis_tdata[38:23];
    assign it.wake_time     = s_axis_tdata[70:39];
    assign it.shell_flag    = s_axis_tdata[71];
    assign it.now_time      = s_axis_tdata[103:72];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pol <= '0; r_pause <= 1'b0; r_ex <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_POLICY: r_pol <= i_cfg_data[1:0];
                REG_PAUSE:  r_pause <= i_cfg_data[0];
                REG_EXEMPT: r_ex <= i_cfg_data;
                default: ;
            endcase
        end
    end

    mpts_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_action(act), .o_cmd(cmd)
    );
    mpts_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .i_item(it), .i_policy(r_pol),
        .i_pause(r_pause), .i_exempt(r_ex), .o_action(act),
        .o_res_pack_dummy(unused_id), .o_ran(ran), .o_slot(cs), .o_id(cid), .o_ticks(tk)
    );
    assign m_axis_tdata = {4'd0, tk, (cid & unused_id), cs, ran};
endmodule

/* tb/multi_policy_task_scheduler_tb.sv */
// self-checking testbench of the multi-policy task scheduler with a built-in predictor
module multi_policy_task_scheduler_tb;
    import mpts_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] ACT_NONE   = 2'd3;
    localparam logic [1:0] ST_UNUSED  = 2'd0;
    localparam logic [1:0] ST_BLOCKED = 2'd3;
    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE = NUM_SLOTS + 8;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [47:0]  m_axis_tdata;
    logic         i_cfg_we = 1'b0;
    logic [1:0]   i_cfg_index = '0;
    logic [7:0]   i_cfg_data = '0;

    multi_policy_task_scheduler DUT (.*);

    // predictor copy of the slot table and registers
    logic [1:0]  tbl_state [NUM_SLOTS];
    logic [7:0]  tbl_id    [NUM_SLOTS];
    logic [7:0]  tbl_prio  [NUM_SLOTS];
    logic [31:0] tbl_runs  [NUM_SLOTS];
    logic [15:0] tbl_burst [NUM_SLOTS];
    logic [31:0] tbl_wake  [NUM_SLOTS];
    logic        tbl_shell [NUM_SLOTS];
    int          rr_start = 0;
    logic [31:0] slice_count = '0;
    logic [1:0]  cur_policy = POL_RR;
    logic        cur_pause = 1'b0;
    logic [7:0]  cur_exempt = '0;

    logic [47:0] pending_reports [$];
    int errors = 0;
    int cycles = 0;
    int items_sent = 0;
    int reports_seen = 0;
    int tasks_ran = 0;
    bit no_idle = 0;
    int hold_req = 0;
    logic [31:0] now_base = '0;
    logic [7:0]  id_pool [4];

    initial begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            tbl_state[i] = ST_UNUSED; tbl_id[i] = '0; tbl_prio[i] = '0; tbl_runs[i] = '0;
            tbl_burst[i] = '0; tbl_wake[i] = '0; tbl_shell[i] = 1'b0;
        end
    end

    // clock
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("multi_policy_task_scheduler regression: fail");
            $finish;
        end
    end

    function automatic logic [103:0] pack_item(logic [1:0] act, logic [2:0] slot,
            logic [7:0] ident, logic [1:0] st, logic [7:0] prio, logic [15:0] burst,
            logic [31:0] wake, logic shell, logic [31:0] now);
        return {now, shell, wake, burst, prio, st, ident, slot, act};
    endfunction

    function automatic bit runnable(int s);
        return tbl_state[s] == ST_READY && (!cur_pause || tbl_id[s] == cur_exempt);
    endfunction

    function automatic bit outranks(int c, int cur);
        case (cur_policy)
            POL_PRIO: return tbl_prio[c] > tbl_prio[cur] ||
                      (tbl_prio[c] == tbl_prio[cur] && tbl_runs[c] < tbl_runs[cur]);
            POL_FCFS: return tbl_id[c] < tbl_id[cur];
            POL_SJF:  return tbl_burst[c] < tbl_burst[cur] ||
                      (tbl_burst[c] == tbl_burst[cur] && tbl_id[c] < tbl_id[cur]);
            default:  return 0;
        endcase
    endfunction

    // apply one item to the predictor and return the expected report
    function automatic logic [47:0] schedule_step(logic [103:0] d);
        logic [1:0]  act;
        int          slot;
        logic [31:0] now;
        int          pick;
        int          shell;
        int          s;
        logic        ran;
        logic [2:0]  cslot;
        logic [7:0]  cid;
        act = d[1:0];
        slot = d[4:2];
        now = d[103:72];
        ran = 0; cslot = '0; cid = '0;
        if (act == ACT_LOAD) begin
            tbl_id[slot] = d[12:5];
            tbl_state[slot] = d[14:13];
            tbl_prio[slot] = d[22:15];
            tbl_burst[slot] = d[38:23];
            tbl_wake[slot] = d[70:39];
            tbl_shell[slot] = d[71];
            tbl_runs[slot] = '0;
        end else if (act == ACT_STATE) begin
            tbl_state[slot] = d[14:13];
            tbl_wake[slot] = d[70:39];
        end else if (act == ACT_SLICE) begin
            for (int i = 0; i < NUM_SLOTS; i++)
                if (tbl_state[i] == ST_SLEEPING && now >= tbl_wake[i]) tbl_state[i] = ST_READY;
            pick = NUM_SLOTS;
            if (cur_policy == POL_RR) begin
                for (int k = NUM_SLOTS - 1; k >= 0; k--) begin
                    s = (rr_start + k) % NUM_SLOTS;
                    if (runnable(s)) pick = s;
                end
            end else begin
                shell = NUM_SLOTS;
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (!runnable(i)) continue;
                    if (tbl_shell[i]) shell = i;
                    else if (pick == NUM_SLOTS || outranks(i, pick)) pick = i;
                end
                if (shell < NUM_SLOTS && (pick == NUM_SLOTS || slice_count[1:0] == 2'd0))
                    pick = shell;
            end
            if (pick < NUM_SLOTS) begin
                rr_start = (pick + 1) % NUM_SLOTS;
                tbl_runs[pick] = tbl_runs[pick] + 1;
                ran = 1; cslot = pick[2:0]; cid = tbl_id[pick];
            end
            slice_count = slice_count + 1;
        end
        return {4'd0, slice_count, cid, cslot, ran};
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 15);
        if (no_idle || r < 9) return 0;
        if (r < 14) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // offer one transaction and predict it on acceptance
    task automatic send_item(logic [103:0] d);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tdata <= d;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        pending_reports.push_back(schedule_step(d));
        items_sent++;
    endtask

    task automatic drain();
        @(posedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // register write while idle
    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_index <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_POLICY: cur_policy = val[1:0];
            REG_PAUSE:  cur_pause = val[0];
            REG_EXEMPT: cur_exempt = val;
            default: ;
        endcase
    endtask

    task automatic set_config(logic [1:0] pol, logic pause, logic [7:0] ex);
        drain();
        write_reg(REG_POLICY, {6'd0, pol});
        write_reg(REG_PAUSE, {7'd0, pause});
        write_reg(REG_EXEMPT, ex);
    endtask

    // receiver: random stalls, plus a long hold on request
    always @(posedge i_clk) begin : sink_ctl
        static int stall_left = 0;
        static int holds_done = 0;
        if (holds_done != hold_req) begin
            holds_done = hold_req;
            stall_left = 300;
        end
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end else if (!no_idle && i_rst_n && $urandom_range(0, 7) == 0) begin
            m_axis_tready <= 1'b0;
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                                                      : $urandom_range(0, 2);
        end else begin
            m_axis_tready <= i_rst_n;
        end
    end

    // compare each report with the oldest expectation
    always @(posedge i_clk) begin : report_check
        logic [47:0] exp_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            reports_seen++;
            if (pending_reports.size() == 0) begin
                $error("unexpected report %h", m_axis_tdata);
                errors++;
            end else begin
                exp_r = pending_reports.pop_front();
                if (exp_r[0]) tasks_ran++;
                if (m_axis_tdata[0] !== exp_r[0]) begin
                    $error("task_ran exp %0d got %0d", exp_r[0], m_axis_tdata[0]); errors++;
                end
                if (m_axis_tdata[3:1] !== exp_r[3:1]) begin
                    $error("chosen_slot exp %0d got %0d", exp_r[3:1], m_axis_tdata[3:1]);
                    errors++;
                end
                if (m_axis_tdata[11:4] !== exp_r[11:4]) begin
                    $error("chosen_id exp %0d got %0d", exp_r[11:4], m_axis_tdata[11:4]);
                    errors++;
                end
                if (m_axis_tdata[43:12] !== exp_r[43:12]) begin
                    $error("tick_total exp %0d got %0d", exp_r[43:12], m_axis_tdata[43:12]);
                    errors++;
                end
            end
        end
    end

    task automatic slice(logic [31:0] now);
        send_item(pack_item(ACT_SLICE, 3'd0, 8'd0, ST_UNUSED, 8'd0, 16'd0, 32'd0, 1'b0, now));
    endtask

    task automatic load(logic [2:0] slot, logic [7:0] ident, logic [1:0] st, logic [7:0] prio,
            logic [15:0] burst, logic [31:0] wake, logic shell);
        send_item(pack_item(ACT_LOAD, slot, ident, st, prio, burst, wake, shell, 32'd0));
    endtask

    // round robin, extremes, wake-up and the unused action code
    task automatic test_round_robin();
        slice(32'd0);
        load(3'd0, 8'hFF, ST_READY, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
        load(3'd7, 8'h00, ST_READY, 8'h00, 16'h0000, 32'h0, 1'b0);
        slice(32'd0);
        slice(32'd0);
        slice(32'hFFFF_FFFF);
        load(3'd3, 8'd5, ST_SLEEPING, 8'd9, 16'd7, 32'd100, 1'b0);
        slice(32'd99);
        slice(32'd100);
        send_item(pack_item(ACT_STATE, 3'd3, 8'd0, ST_BLOCKED, 8'd0, 16'd0, 32'd0, 1'b0, 32'd0));
        slice(32'd200);
        send_item(pack_item(ACT_NONE, 3'd7, 8'hFF, 2'd3, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF,
                            1'b1, 32'hFFFF_FFFF));
    endtask

    // priority, fcfs and sjf with a shell task and ties
    task automatic test_policies();
        load(3'd1, 8'd40, ST_READY, 8'd9, 16'd7, 32'd0, 1'b1);
        load(3'd3, 8'd5, ST_READY, 8'hFF, 16'd7, 32'd0, 1'b0);
        for (int p = 1; p < 4; p++) begin
            set_config(p[1:0], 1'b0, 8'd0);
            repeat (5) slice(32'd300);
        end
    endtask

    // pause with exempt id present and absent
    task automatic test_pause();
        set_config(POL_RR, 1'b1, 8'd5);
        repeat (2) slice(32'd0);
        set_config(POL_PRIO, 1'b1, 8'd77);
        slice(32'd0);
    endtask

    function automatic logic [7:0] rand_id();
        return ($urandom_range(0, 1) == 0) ? id_pool[$urandom_range(0, 3)] : 8'($urandom);
    endfunction

    function automatic logic [1:0] rand_state();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return ST_READY;
        if (r < 8) return ST_SLEEPING;
        return (r == 8) ? ST_UNUSED : ST_BLOCKED;
    endfunction

    function automatic logic [31:0] rand_wake();
        return ($urandom_range(0, 4) == 0) ? $urandom : now_base + $urandom_range(0, 40);
    endfunction

    task automatic random_phase(int count);
        int r;
        logic [31:0] now;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 30)
                load(3'($urandom), rand_id(), rand_state(),
                     ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 3)) : 8'($urandom),
                     ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 3)) : 16'($urandom),
                     rand_wake(), $urandom_range(0, 6) == 0);
            else if (r < 45)
                send_item(pack_item(ACT_STATE, 3'($urandom), 8'($urandom), rand_state(),
                                    8'($urandom), 16'($urandom), rand_wake(), 1'($urandom),
                                    $urandom));
            else if (r < 95) begin
                now_base = now_base + $urandom_range(0, 20);
                now = ($urandom_range(0, 19) == 0) ? $urandom : now_base;
                send_item(pack_item(ACT_SLICE, 3'($urandom), 8'($urandom), 2'($urandom),
                                    8'($urandom), 16'($urandom), $urandom, 1'($urandom), now));
            end else
                send_item(pack_item(ACT_NONE, 3'($urandom), 8'($urandom), 2'($urandom),
                                    8'($urandom), 16'($urandom), $urandom, 1'($urandom),
                                    $urandom));
        end
    endtask

    task automatic test_random();
        for (int ph = 0; ph < 10; ph++) begin
            id_pool[0] = 8'd0; id_pool[1] = 8'hFF;
            id_pool[2] = 8'($urandom); id_pool[3] = 8'($urandom);
            if (ph < 4) set_config(ph[1:0], 1'b0, 8'($urandom));
            else if (ph < 8) set_config(ph[1:0], 1'b1, id_pool[ph % 4]);
            else set_config(2'($urandom), 1'($urandom), id_pool[$urandom_range(0, 3)]);
            no_idle = (ph == 5);
            random_phase(ph == 9 ? 100 : 140);
        end
        no_idle = 0;
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_backpressure();
        set_config(POL_SJF, 1'b0, 8'd0);
        hold_req = hold_req + 1;
        random_phase(12);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);
        test_round_robin();
        test_policies();
        test_pause();
        test_random();
        test_backpressure();
        drain();
        $display("covered %0d transactions, %0d reports, %0d slices that ran a task",
                 items_sent, reports_seen, tasks_ran);
        $display("all four policies, pause with and without exempt task, shell favoring");
        if (errors == 0) begin
            $display("multi_policy_task_scheduler regression: pass");
        end else begin
            $display("multi_policy_task_scheduler regression: fail");
        end
        $finish;
    end
endmodule
